// ===== hdl/pair_gravity_acceleration_top_assert.svh =====
// Assertion macros for the pair gravity acceleration block.
`ifndef PAIR_GRAVITY_ACCELERATION_TOP_ASSERT_SVH
`define PAIR_GRAVITY_ACCELERATION_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PGA_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PGA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pga_pkg.sv =====
// Package: constants and types of the pair gravity acceleration block.
`default_nettype none

package pga_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int COEF_FRAC_BITS    = 24;
  localparam logic [31:0] GRAVITY_RESET = 32'h0100_0000;

  // root of a 66-bit sum of squares: one result bit per step
  localparam int SQRT_STEPS = 34;
  // one quotient bit per step, 32-bit results
  localparam int DIV_STEPS  = 32;
  // holds numerator and divisor shifted by the full quotient width
  localparam int DIV_W      = 140;

  typedef struct packed {
    logic neg_x;
    logic pos_x;
    logic neg_y;
    logic pos_y;
    logic coin;
  } flags_t;

  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic [63:0] g1;
    logic [63:0] g2;
    flags_t      fl;
  } side_t;

endpackage

`default_nettype wire

// ===== hdl/pair_gravity_acceleration_top.sv =====
// Top level: pipelined pair gravity acceleration in fixed point.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | in        | in_valid_i / in_stall_o   | masses, positions of two bodies
//  out     | out       | out_valid_o / out_stall_i | four accelerations, flags
//  coef    | in        | gravity_coefficient_we_i  | gravity_coefficient_i (Q8.24)
//
// One request per cycle while no stall holds the pipeline. There are 73 register
// stages; most of them are the 34 root steps and the 32 quotient steps, with one
// register stage each.
// Reset clears the valid bits and loads the coefficient with 1.0.
// A stall only holds stages that carry a request; bubbles ahead of it close up,
// so input is taken while a result waits until the pipeline is full.
`default_nettype none

module pair_gravity_acceleration_top #(
  parameter int FRACTION_BITS = pga_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               gravity_coefficient_we_i,
  input  logic [31:0]        gravity_coefficient_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        mass_first_i,
  input  logic [31:0]        mass_second_i,
  input  logic signed [31:0] x_first_i,
  input  logic signed [31:0] y_first_i,
  input  logic signed [31:0] x_second_i,
  input  logic signed [31:0] y_second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] accel_x_first_o,
  output logic signed [31:0] accel_y_first_o,
  output logic signed [31:0] accel_x_second_o,
  output logic signed [31:0] accel_y_second_o,
  output logic               coincident_o,
  output logic               saturated_o
);

  localparam int SHIFT  = 2 * FRACTION_BITS - pga_pkg::COEF_FRAC_BITS;
  localparam int NUM_SH = (SHIFT > 0) ? SHIFT : 0;
  localparam int DEN_SH = (SHIFT < 0) ? -SHIFT : 0;
  localparam int SQ     = pga_pkg::SQRT_STEPS;
  localparam int DV     = pga_pkg::DIV_STEPS;
  localparam int W      = pga_pkg::DIV_W;

  localparam int ST_SQ0 = 3;
  localparam int ST_PP  = ST_SQ0 + SQ;
  localparam int ST_T   = ST_PP + 1;
  localparam int ST_SH  = ST_T + 1;
  localparam int ST_DV0 = ST_SH + 1;
  localparam int ST_OUT = ST_DV0 + DV;
  localparam int NST    = ST_OUT + 1;

  // ---------------- control ----------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  assign en[NST-1] = !vld_q[NST-1] || !out_stall_i;
  for (genvar i = 0; i < NST - 1; i++) begin : g_en
    assign en[i] = !vld_q[i] || en[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NST-1];

  logic [31:0] k_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= pga_pkg::GRAVITY_RESET;
    end else if (gravity_coefficient_we_i) begin
      k_q <= gravity_coefficient_i;
    end
  end

  // ---------------- stage 0: displacement ----------------
  logic signed [32:0] dx, dy;
  logic [32:0]        ax0_q, ay0_q;
  logic [31:0]        m1_q, m2_q;
  pga_pkg::flags_t    fl0_q;

  assign dx = 33'(x_second_i) - 33'(x_first_i);
  assign dy = 33'(y_second_i) - 33'(y_first_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax0_q       <= dx[32] ? 33'(-dx) : 33'(dx);
      ay0_q       <= dy[32] ? 33'(-dy) : 33'(dy);
      m1_q        <= mass_first_i;
      m2_q        <= mass_second_i;
      fl0_q.neg_x <= dx[32];
      fl0_q.pos_x <= !dx[32] && (dx != '0);
      fl0_q.neg_y <= dy[32];
      fl0_q.pos_y <= !dy[32] && (dy != '0);
      fl0_q.coin  <= (dx == '0) && (dy == '0);
    end
  end

  // ---------------- stage 1: squares, coefficient times mass ----------------
  logic [64:0]     sx1_q, sy1_q;
  pga_pkg::side_t  side1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sx1_q      <= ax0_q * ax0_q;
      sy1_q      <= ay0_q * ay0_q;
      side1_q.ax <= ax0_q;
      side1_q.ay <= ay0_q;
      side1_q.g1 <= k_q * m1_q;
      side1_q.g2 <= k_q * m2_q;
      side1_q.fl <= fl0_q;
    end
  end

  // ---------------- stage 2: sum of squares ----------------
  logic [65:0]    s2_q;
  pga_pkg::side_t side2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_q    <= 66'(sx1_q) + 66'(sy1_q);
      side2_q <= side1_q;
    end
  end

  // ---------------- square root, one bit per stage ----------------
  logic [65:0]    sq_s_q    [SQ];
  logic [35:0]    sq_rem_q  [SQ];
  logic [33:0]    sq_root_q [SQ];
  pga_pkg::side_t sq_side_q [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [65:0]       s_in;
    logic [35:0]       rem_in;
    logic [33:0]       root_in;
    pga_pkg::side_t    side_in;
    logic [2*SQ-1:0]   s_pad;
    logic [35:0]       rem_sh, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign s_in    = s2_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side2_q;
    end else begin : g_next
      assign s_in    = sq_s_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign side_in = sq_side_q[k-1];
    end

    assign s_pad  = (2*SQ)'(s_in);
    assign rem_sh = {rem_in[33:0], s_pad[2*SQ-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en[ST_SQ0+k]) begin
        sq_s_q[k]    <= s_in;
        sq_rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_q[k] <= {root_in[32:0], ge};
        sq_side_q[k] <= side_in;
      end
    end
  end

  // ---------------- partial products of divisor and numerators ----------------
  logic [65:0]     pp_lo_q;
  logic [67:0]     pp_hi_q;
  logic [64:0]     nlo_q [4];
  logic [64:0]     nhi_q [4];
  pga_pkg::flags_t pp_fl_q;

  logic [65:0]    sq_s_last;
  logic [33:0]    sq_r_last;
  pga_pkg::side_t sq_sd_last;

  assign sq_s_last  = sq_s_q[SQ-1];
  assign sq_r_last  = sq_root_q[SQ-1];
  assign sq_sd_last = sq_side_q[SQ-1];

  always_ff @(posedge clk_i) begin
    if (en[ST_PP]) begin
      pp_lo_q <= sq_s_last[31:0] * sq_r_last;
      pp_hi_q <= sq_s_last[65:32] * sq_r_last;
      pp_fl_q <= sq_sd_last.fl;
    end
  end

  // outputs: 0 x first, 1 y first, 2 x second, 3 y second
  for (genvar j = 0; j < 4; j++) begin : g_num
    logic [63:0] g;
    logic [32:0] a;
    assign g = (j < 2) ? sq_sd_last.g2 : sq_sd_last.g1;
    assign a = (j % 2 == 0) ? sq_sd_last.ax : sq_sd_last.ay;
    always_ff @(posedge clk_i) begin
      if (en[ST_PP]) begin
        nlo_q[j] <= g[31:0] * a;
        nhi_q[j] <= g[63:32] * a;
      end
    end
  end

  // ---------------- assemble and scale ----------------
  logic [W-1:0]    den_q;
  logic [W-1:0]    num_q [4];
  pga_pkg::flags_t t_fl_q;
  logic [99:0]     t_full;

  assign t_full = 100'(pp_lo_q) + (100'(pp_hi_q) << 32);

  always_ff @(posedge clk_i) begin
    if (en[ST_T]) begin
      den_q  <= W'(t_full) << DEN_SH;
      t_fl_q <= pp_fl_q;
      for (int j = 0; j < 4; j++) begin
        num_q[j] <= W'(97'(nlo_q[j]) + (97'(nhi_q[j]) << 32)) << NUM_SH;
      end
    end
  end

  // ---------------- quotient range check ----------------
  logic [W-1:0]    sh_den_q;
  logic [W-1:0]    sh_rem_q [4];
  logic [3:0]      sh_ovf_q;
  pga_pkg::flags_t sh_fl_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SH]) begin
      sh_den_q <= den_q;
      sh_fl_q  <= t_fl_q;
      for (int j = 0; j < 4; j++) begin
        sh_rem_q[j] <= num_q[j];
        sh_ovf_q[j] <= num_q[j] >= (den_q << DV);
      end
    end
  end

  // ---------------- restoring division, one bit per stage ----------------
  logic [W-1:0]    dv_den_q [DV-1];
  logic [W-1:0]    dv_rem_q [DV-1][4];
  logic [DV-1:0]   dv_q_q   [DV][4];
  logic [3:0]      dv_ovf_q [DV];
  pga_pkg::flags_t dv_fl_q  [DV];

  for (genvar d = 0; d < DV; d++) begin : g_div
    logic [W-1:0]    den_in, dsh;
    logic [W-1:0]    rem_in [4];
    logic [DV-1:0]   q_in   [4];
    logic [3:0]      ovf_in;
    pga_pkg::flags_t fl_in;
    logic [3:0]      ge;

    if (d == 0) begin : g_first
      assign den_in = sh_den_q;
      assign ovf_in = sh_ovf_q;
      assign fl_in  = sh_fl_q;
      for (genvar j = 0; j < 4; j++) begin : g_l
        assign rem_in[j] = sh_rem_q[j];
        assign q_in[j]   = '0;
      end
    end else begin : g_next
      assign den_in = dv_den_q[d-1];
      assign ovf_in = dv_ovf_q[d-1];
      assign fl_in  = dv_fl_q[d-1];
      for (genvar j = 0; j < 4; j++) begin : g_l
        assign rem_in[j] = dv_rem_q[d-1][j];
        assign q_in[j]   = dv_q_q[d-1][j];
      end
    end

    assign dsh = den_in << (DV - 1 - d);

    for (genvar j = 0; j < 4; j++) begin : g_lane
      assign ge[j] = rem_in[j] >= dsh;
      always_ff @(posedge clk_i) begin
        if (en[ST_DV0+d]) begin
          dv_q_q[d][j] <= {q_in[j][DV-2:0], ge[j]};
        end
      end
      if (d < DV - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en[ST_DV0+d]) begin
            dv_rem_q[d][j] <= ge[j] ? rem_in[j] - dsh : rem_in[j];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_DV0+d]) begin
        dv_ovf_q[d] <= ovf_in;
        dv_fl_q[d]  <= fl_in;
      end
    end

    if (d < DV - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en[ST_DV0+d]) dv_den_q[d] <= den_in;
      end
    end
  end

  // ---------------- sign, clip, output register ----------------
  logic signed [31:0] acc_d [4];
  logic [3:0]         sat_d;
  logic signed [31:0] acc_q [4];
  logic               coin_q, sat_q;
  pga_pkg::flags_t    fl_l;

  assign fl_l = dv_fl_q[DV-1];

  for (genvar j = 0; j < 4; j++) begin : g_fin
    logic        neg;
    logic [31:0] q, lim, mag;
    assign neg = (j == 0) ? fl_l.neg_x :
                 (j == 1) ? fl_l.neg_y :
                 (j == 2) ? fl_l.pos_x : fl_l.pos_y;
    assign q   = dv_q_q[DV-1][j];
    assign lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat_d[j] = dv_ovf_q[DV-1][j] || (q > lim);
    assign mag      = sat_d[j] ? lim : q;
    assign acc_d[j] = neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      coin_q <= fl_l.coin;
      sat_q  <= !fl_l.coin && (sat_d != '0);
      for (int j = 0; j < 4; j++) begin
        acc_q[j] <= fl_l.coin ? '0 : acc_d[j];
      end
    end
  end

  assign accel_x_first_o  = acc_q[0];
  assign accel_y_first_o  = acc_q[1];
  assign accel_x_second_o = acc_q[2];
  assign accel_y_second_o = acc_q[3];
  assign coincident_o     = coin_q;
  assign saturated_o      = sat_q;

endmodule

`default_nettype wire

// ===== hdl/pga_checker.sv =====
// Port checker for the pair gravity acceleration block, bound to the top level.
`default_nettype none
`include "pair_gravity_acceleration_top_assert.svh"

module pga_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               gravity_coefficient_we_i,
  input logic [31:0]        gravity_coefficient_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [31:0]        mass_first_i,
  input logic [31:0]        mass_second_i,
  input logic signed [31:0] x_first_i,
  input logic signed [31:0] y_first_i,
  input logic signed [31:0] x_second_i,
  input logic signed [31:0] y_second_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] accel_x_first_o,
  input logic signed [31:0] accel_y_first_o,
  input logic signed [31:0] accel_x_second_o,
  input logic signed [31:0] accel_y_second_o,
  input logic               coincident_o,
  input logic               saturated_o
);

  logic         acc_zero;
  logic         out_held;
  logic [129:0] res_w;

  assign acc_zero = (accel_x_first_o == 0) && (accel_y_first_o == 0) &&
                    (accel_x_second_o == 0) && (accel_y_second_o == 0);
  assign out_held = out_valid_o && out_stall_i;
  assign res_w    = {accel_x_first_o, accel_y_first_o, accel_x_second_o,
                     accel_y_second_o, coincident_o, saturated_o};

  // coincident bodies give zero on all four outputs
  `PGA_ASSERT_ALWAYS(a_coin_zero, !(out_valid_o && coincident_o) || acc_zero, "coincident result not zero")

  // nothing is clipped when the positions coincide
  `PGA_ASSERT_ALWAYS(a_coin_nosat, !(out_valid_o && coincident_o) || !saturated_o, "saturated set on coincident result")

  // an empty output stage never pushes back on the input
  `PGA_ASSERT_ALWAYS(a_no_false_stall, out_valid_o || !in_stall_o, "input stalled with output empty")

  // a stalled result holds
  `PGA_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(res_w), "stalled result changed")

endmodule

bind pair_gravity_acceleration_top pga_checker u_pga_checker (.*);

`default_nettype wire
